// ===== rtl/core/rmod_pkg.sv =====
`default_nettype none

package rmod_pkg;

    // Datapath widths
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = 32;
    localparam int SIGMA_W     = 16;
    localparam int FRACT_W     = 8;
    localparam int MINS_W      = 8;
    localparam int CFG_W       = 16;
    localparam int SEV_W       = 7;

    // Binary point positions of sigma (Q8.8) and of the speed fraction (Q0.8)
    localparam int SIGMA_SCALE = 8;
    localparam int FRACT_SCALE = 8;

    localparam int MPL_W     = SIGMA_W + FRACT_W;
    localparam int PROD_W    = VALUE_WIDTH + MPL_W;
    localparam int MAX_STEPS = (VALUE_WIDTH > MPL_W) ? VALUE_WIDTH : MPL_W;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRACT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MINS   = 2'd3;

    localparam logic               ENABLE_RST = 1'b1;
    localparam logic [SIGMA_W-1:0] SIGMA_RST  = 16'd768;
    localparam logic [FRACT_W-1:0] FRACT_RST  = 8'd77;
    localparam logic [MINS_W-1:0]  MINS_RST   = 8'd10;

    // Field codes
    localparam logic REQ_OBSERVE = 1'b0;
    localparam logic REQ_CHECK   = 1'b1;
    localparam logic KIND_DELAY  = 1'b0;
    localparam logic KIND_SPEED  = 1'b1;
    localparam logic HINT_SLOW   = 1'b0;
    localparam logic HINT_FAST   = 1'b1;
    localparam logic [SEV_W-1:0] SEV_DELAY = 7'd75;
    localparam logic [SEV_W-1:0] SEV_SPEED = 7'd65;

    typedef struct packed {
        logic                   req_type;
        logic                   has_delay;
        logic [VALUE_WIDTH-1:0] delay_value;
        logic                   has_spread;
        logic [VALUE_WIDTH-1:0] spread_value;
        logic                   has_speed;
        logic [VALUE_WIDTH-1:0] speed_value;
    } req_t;

    typedef struct packed {
        logic             anomaly_kind;
        logic             hint;
        logic [SEV_W-1:0] severity_pct;
        logic             last;
    } rsp_t;

    // Control of one bit-serial lane
    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/rmod_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per step
module rmod_div
    import rmod_pkg::*;
(
    input  wire logic                   clk,
    input  wire lane_ctl_t              ctl,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [COUNT_W-1:0]     divisor,
    output logic      [VALUE_WIDTH-1:0] quotient
);

    logic [COUNT_W-1:0]     rem_reg;
    logic [COUNT_W-1:0]     rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic [COUNT_W-1:0]     dvs_reg;
    logic [COUNT_W:0]       shifted;
    logic [COUNT_W+1:0]     trial;
    logic                   fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        trial    = {1'b0, shifted} - {2'b00, dvs_reg};
        fits     = ~trial[COUNT_W+1];
        rem_next = fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
        quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (ctl.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rmod_mul.sv =====
`default_nettype none

// Shift-add multiplier, one multiplier bit per step
module rmod_mul
    import rmod_pkg::*;
(
    input  wire logic                   clk,
    input  wire lane_ctl_t              ctl,
    input  wire logic [VALUE_WIDTH-1:0] mcand,
    input  wire logic [MPL_W-1:0]       mplier,
    output logic      [PROD_W-1:0]      product
);

    logic [VALUE_WIDTH-1:0] hi_reg;
    logic [VALUE_WIDTH-1:0] hi_next;
    logic [MPL_W-1:0]       lo_reg;
    logic [MPL_W-1:0]       lo_next;
    logic [VALUE_WIDTH-1:0] mcand_reg;
    logic [VALUE_WIDTH:0]   sum;

    always_comb
    begin
        sum     = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        hi_next = sum[VALUE_WIDTH:1];
        lo_next = {sum[0], lo_reg[MPL_W-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            hi_reg    <= '0;
            lo_reg    <= mplier;
            mcand_reg <= mcand;
        end
        else if (ctl.step)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ===== rtl/core/running_mean_outlier_detector_top.sv =====
// Observe transaction: three bit-serial dividers, one bit a cycle.
// Check transaction (only if enabled and count > mins): two shift-add multipliers, one bit a cycle,
//   results compared when the steps end; a check holds until the two-entry output buffer drains.
// One transaction at a time; req_ready is high whenever the sequencer is idle.
// Reset (rst_n low, async): count and means zero, registers at defaults, buffer empty.
`default_nettype none

module running_mean_outlier_detector_top
    import rmod_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire req_t                 req_data,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output rsp_t                      rsp_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_DIV    = 6'b000100,
        S_UPDATE = 6'b001000,
        S_MUL    = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    function automatic logic [VALUE_WIDTH-1:0] abs_diff(
        input logic [VALUE_WIDTH-1:0] a,
        input logic [VALUE_WIDTH-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    state_t                 state_reg;
    state_t                 state_next;
    logic [STEP_W-1:0]      step_cnt_reg;
    req_t                   item_reg;

    logic                   enable_reg;
    logic [SIGMA_W-1:0]     sigma_reg;
    logic [FRACT_W-1:0]     fract_reg;
    logic [MINS_W-1:0]      mins_reg;

    logic [COUNT_W-1:0]     sample_count_reg;
    logic [COUNT_W-1:0]     sample_count_next;
    logic [VALUE_WIDTH-1:0] mean_delay_reg;
    logic [VALUE_WIDTH-1:0] mean_spread_reg;
    logic [VALUE_WIDTH-1:0] mean_speed_reg;

    logic [2:0]             neg_reg;
    logic [VALUE_WIDTH-1:0] dd_reg;
    logic [VALUE_WIDTH-1:0] ds_reg;
    logic                   hint_d_reg;
    logic                   hint_s_reg;

    rsp_t                   slot0_reg;
    rsp_t                   slot1_reg;
    logic                   v0_reg;
    logic                   v1_reg;

    lane_ctl_t              div_ctl;
    lane_ctl_t              mul_ctl;
    logic [VALUE_WIDTH-1:0] q_delay;
    logic [VALUE_WIDTH-1:0] q_spread;
    logic [VALUE_WIDTH-1:0] q_speed;
    logic [PROD_W-1:0]      prod_d;
    logic [PROD_W-1:0]      prod_s;
    logic [MPL_W-1:0]       speed_mul;

    logic                   is_obs;
    logic                   run_check;
    logic                   step_last;
    logic [PROD_W-1:0]      cmp_d;
    logic [PROD_W-1:0]      cmp_s;
    logic                   flag_d;
    logic                   flag_s;
    logic                   buf_empty;
    logic                   emit_load;
    logic                   pop;
    rsp_t                   res_d;
    rsp_t                   res_s;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = v0_reg;
    assign rsp_data  = slot0_reg;
    assign pop       = v0_reg && rsp_ready;
    assign buf_empty = !v0_reg && !v1_reg;

    assign is_obs    = (item_reg.req_type == REQ_OBSERVE);
    assign run_check = enable_reg && (sample_count_reg > COUNT_W'(mins_reg));
    assign step_last = (step_cnt_reg == '0);

    assign sample_count_next = (sample_count_reg == '1) ? sample_count_reg
                                                        : sample_count_reg + 1'b1;

    assign speed_mul = {{FRACT_W{1'b0}}, sigma_reg} * {{SIGMA_W{1'b0}}, fract_reg};

    always_comb
    begin
        div_ctl.load = (state_reg == S_LOAD) && is_obs;
        div_ctl.step = (state_reg == S_DIV);
        mul_ctl.load = (state_reg == S_LOAD) && !is_obs && run_check;
        mul_ctl.step = (state_reg == S_MUL);
    end

    rmod_div u_div_delay (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (abs_diff(item_reg.delay_value, mean_delay_reg)),
        .divisor  (sample_count_next),
        .quotient (q_delay)
    );

    rmod_div u_div_spread (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (abs_diff(item_reg.spread_value, mean_spread_reg)),
        .divisor  (sample_count_next),
        .quotient (q_spread)
    );

    rmod_div u_div_speed (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (abs_diff(item_reg.speed_value, mean_speed_reg)),
        .divisor  (sample_count_next),
        .quotient (q_speed)
    );

    rmod_mul u_mul_delay (
        .clk     (clk),
        .ctl     (mul_ctl),
        .mcand   (mean_spread_reg),
        .mplier  ({{FRACT_W{1'b0}}, sigma_reg}),
        .product (prod_d)
    );

    rmod_mul u_mul_speed (
        .clk     (clk),
        .ctl     (mul_ctl),
        .mcand   (mean_speed_reg),
        .mplier  (speed_mul),
        .product (prod_s)
    );

    // Exact limit compares against the serial products
    always_comb
    begin
        cmp_d  = {{(PROD_W-VALUE_WIDTH-SIGMA_SCALE){1'b0}}, dd_reg, {SIGMA_SCALE{1'b0}}};
        cmp_s  = {{(PROD_W-VALUE_WIDTH-SIGMA_SCALE-FRACT_SCALE){1'b0}}, ds_reg,
                  {(SIGMA_SCALE+FRACT_SCALE){1'b0}}};
        flag_d = item_reg.has_delay && (mean_spread_reg != '0) && (cmp_d > prod_d);
        flag_s = item_reg.has_speed && (mean_speed_reg != '0) && (fract_reg != '0)
                 && (cmp_s > prod_s);

        res_d.anomaly_kind = KIND_DELAY;
        res_d.hint         = hint_d_reg;
        res_d.severity_pct = SEV_DELAY;
        res_d.last         = !flag_s;

        res_s.anomaly_kind = KIND_SPEED;
        res_s.hint         = hint_s_reg;
        res_s.severity_pct = SEV_SPEED;
        res_s.last         = 1'b1;

        emit_load = (state_reg == S_EMIT) && buf_empty && (flag_d || flag_s);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (is_obs)
                    state_next = S_DIV;
                else if (run_check)
                    state_next = S_MUL;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (step_last)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            S_MUL:
            begin
                if (step_last)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the buffer drains when there is something to emit
                if (!(flag_d || flag_s) || buf_empty)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOAD)
                step_cnt_reg <= is_obs ? STEP_W'(VALUE_WIDTH - 1) : STEP_W'(MPL_W - 1);
            else if ((state_reg == S_DIV) || (state_reg == S_MUL))
                step_cnt_reg <= step_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            item_reg <= req_data;
        if (state_reg == S_LOAD)
        begin
            neg_reg[0] <= item_reg.delay_value  < mean_delay_reg;
            neg_reg[1] <= item_reg.spread_value < mean_spread_reg;
            neg_reg[2] <= item_reg.speed_value  < mean_speed_reg;
            dd_reg     <= abs_diff(item_reg.delay_value, mean_delay_reg);
            ds_reg     <= abs_diff(item_reg.speed_value, mean_speed_reg);
            hint_d_reg <= (item_reg.delay_value < mean_delay_reg) ? HINT_SLOW : HINT_FAST;
            hint_s_reg <= (item_reg.speed_value > mean_speed_reg) ? HINT_SLOW : HINT_FAST;
        end
        if (emit_load)
        begin
            slot0_reg <= flag_d ? res_d : res_s;
            slot1_reg <= res_s;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            v0_reg <= 1'b1;
            v1_reg <= flag_d && flag_s;
        end
        else if (pop)
        begin
            v0_reg <= v1_reg;
            v1_reg <= 1'b0;
        end
    end

    // Baseline state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            mean_delay_reg   <= '0;
            mean_spread_reg  <= '0;
            mean_speed_reg   <= '0;
        end
        else
        begin
            if (div_ctl.load)
                sample_count_reg <= sample_count_next;
            if (state_reg == S_UPDATE)
            begin
                if (item_reg.has_delay)
                    mean_delay_reg <= neg_reg[0] ? mean_delay_reg - q_delay
                                                 : mean_delay_reg + q_delay;
                if (item_reg.has_spread)
                    mean_spread_reg <= neg_reg[1] ? mean_spread_reg - q_spread
                                                  : mean_spread_reg + q_spread;
                if (item_reg.has_speed)
                    mean_speed_reg <= neg_reg[2] ? mean_speed_reg - q_speed
                                                 : mean_speed_reg + q_speed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= ENABLE_RST;
            sigma_reg  <= SIGMA_RST;
            fract_reg  <= FRACT_RST;
            mins_reg   <= MINS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_wdata[0];
                REG_SIGMA:  sigma_reg  <= cfg_wdata[SIGMA_W-1:0];
                REG_FRACT:  fract_reg  <= cfg_wdata[FRACT_W-1:0];
                REG_MINS:   mins_reg   <= cfg_wdata[MINS_W-1:0];
                default:    enable_reg <= enable_reg;
            endcase
        end
    end

    a_buf_order: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> v0_reg)
        else $error("second output slot valid with empty head");

    a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.last) |-> v1_reg)
        else $error("non-final anomaly without a queued follower");

    a_emit_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && buf_empty) |=> (state_reg == S_IDLE))
        else $error("emit stalled with an empty output buffer");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (sample_count_reg >= $past(sample_count_reg)))
        else $error("sample count decreased");

endmodule

`default_nettype wire
